@@ hdl/des_pkg.sv @@
// shared types, tables and permutation functions for the des / triple des core
package des_pkg;

   localparam int KeyWidth   = 64;
   localparam int BlockWidth = 64;
   localparam int HalfWidth  = 32;
   localparam int CdWidth    = 28;
   localparam int SubkeyWidth = 48;

   localparam logic [1:0] CSR_KEY_ONE       = 2'd0;
   localparam logic [1:0] CSR_KEY_TWO       = 2'd1;
   localparam logic [1:0] CSR_TRIPLE_ENABLE = 2'd2;

   localparam logic [1:0] PASS_FIRST  = 2'd0;
   localparam logic [1:0] PASS_MIDDLE = 2'd1;
   localparam logic [1:0] PASS_LAST   = 2'd2;

   localparam logic [3:0] ROUND_FIRST = 4'd0;
   localparam logic [3:0] ROUND_LAST  = 4'd15;

   // bit i set when round i of the key schedule rotates by two
   localparam logic [15:0] SHIFT_TWO = 16'h7EFC;

   typedef struct packed {
      logic load;
      logic round;
      logic pass_done;
      logic finish;
      logic decrypt;
      logic shift_two;
      logic key_two_sel;
   } des_cmd_type;

   localparam logic [6:0] PC1_TAB [56] = '{
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
      7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
      7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
      7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
      7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};

   localparam logic [6:0] PC2_TAB [48] = '{
      7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
      7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,  7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
      7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55, 7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
      7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32};

   localparam logic [6:0] IP_TAB [64] = '{
      7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
      7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
      7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
      7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
      7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
      7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
      7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

   localparam logic [6:0] FP_TAB [64] = '{
      7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
      7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
      7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
      7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
      7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
      7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
      7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
      7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};

   localparam logic [5:0] E_TAB [48] = '{
      6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
      6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
      6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
      6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1};

   localparam logic [5:0] P_TAB [32] = '{
      6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
      6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
      6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
      6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25};

   localparam logic [3:0] SBOX_TAB [8][64] = '{
      '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
        4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
        4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
        4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
      '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
        4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
        4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
        4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
      '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
        4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
        4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
        4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
      '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
        4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
        4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
        4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
      '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
        4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
        4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
        4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
      '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
        4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
        4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
        4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
      '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
        4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
        4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
        4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
      '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
        4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
        4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
        4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

   function automatic logic [55:0] pc1_perm(input logic [63:0] x);
      logic [55:0] y;
      y = '0;
      for (int i = 0; i < 56; i++) begin
         y[55 - i] = x[64 - PC1_TAB[i]];
      end
      return y;
   endfunction

   function automatic logic [47:0] pc2_perm(input logic [55:0] x);
      logic [47:0] y;
      y = '0;
      for (int i = 0; i < 48; i++) begin
         y[47 - i] = x[56 - PC2_TAB[i]];
      end
      return y;
   endfunction

   function automatic logic [63:0] ip_perm(input logic [63:0] x);
      logic [63:0] y;
      y = '0;
      for (int i = 0; i < 64; i++) begin
         y[63 - i] = x[64 - IP_TAB[i]];
      end
      return y;
   endfunction

   function automatic logic [63:0] fp_perm(input logic [63:0] x);
      logic [63:0] y;
      y = '0;
      for (int i = 0; i < 64; i++) begin
         y[63 - i] = x[64 - FP_TAB[i]];
      end
      return y;
   endfunction

   function automatic logic [27:0] rot_left(input logic [27:0] v, input logic two);
      logic [27:0] y;
      y = two ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
      return y;
   endfunction

   function automatic logic [27:0] rot_right(input logic [27:0] v, input logic two);
      logic [27:0] y;
      y = two ? {v[1:0], v[27:2]} : {v[0], v[27:1]};
      return y;
   endfunction

   // expansion, key mix, s-boxes and p permutation of one round
   function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] e;
      logic [5:0]  six;
      logic [31:0] s;
      logic [31:0] y;
      e = '0;
      for (int i = 0; i < 48; i++) begin
         e[47 - i] = r[32 - E_TAB[i]];
      end
      e = e ^ k;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         six = e[47 - 6 * i -: 6];
         s[31 - 4 * i -: 4] = SBOX_TAB[i][{six[5], six[0], six[4:1]}];
      end
      y = '0;
      for (int i = 0; i < 32; i++) begin
         y[31 - i] = s[32 - P_TAB[i]];
      end
      return y;
   endfunction

endpackage

@@ hdl/des_ctrl.sv @@
// round and pass sequencer for the des / triple des core
module des_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 mode,
   input  logic                 triple,
   output logic                 busy,
   output des_pkg::des_cmd_type cmd
);
   import des_pkg::*;

   typedef enum logic [0:0] {
      S_IDLE,
      S_ROUND
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] round_ff, round_in;
   logic [1:0] pass_ff, pass_in;
   logic       dec_ff, dec_in;
   logic [3:0] shift_idx;
   logic       last_round;
   logic       last_pass;

   always_comb begin
      last_round      = (round_ff == ROUND_LAST);
      last_pass       = !triple || (pass_ff == PASS_LAST);
      cmd.load        = start && (state_ff == S_IDLE);
      cmd.round       = (state_ff == S_ROUND);
      cmd.decrypt     = dec_ff ^ (pass_ff == PASS_MIDDLE);
      shift_idx       = cmd.decrypt ? (ROUND_LAST - round_ff) : round_ff;
      cmd.shift_two   = SHIFT_TWO[shift_idx];
      cmd.pass_done   = cmd.round && last_round && !last_pass;
      cmd.finish      = cmd.round && last_round && last_pass;
      cmd.key_two_sel = (pass_ff == PASS_FIRST);
      busy            = (state_ff == S_ROUND);
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      pass_in  = pass_ff;
      dec_in   = dec_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_ROUND;
               round_in = ROUND_FIRST;
               pass_in  = PASS_FIRST;
               dec_in   = mode;
            end
         end
         S_ROUND: begin
            round_in = round_ff + 4'd1;
            if (last_round) begin
               if (last_pass) begin
                  state_in = S_IDLE;
                  pass_in  = PASS_FIRST;
               end else begin
                  pass_in = pass_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         round_ff <= ROUND_FIRST;
         pass_ff  <= PASS_FIRST;
         dec_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         pass_ff  <= pass_in;
         dec_ff   <= dec_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> busy && (round_ff == ROUND_FIRST) && (pass_ff == PASS_FIRST))
      else $error("accepted transaction did not start at round zero");

   a_round_steps: assert property (@(posedge clock) disable iff (reset)
      busy && !last_round |=> busy && (round_ff == $past(round_ff) + 4'd1))
      else $error("round counter skipped");

   a_finish_idles: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !busy && (pass_ff == PASS_FIRST))
      else $error("sequencer still busy after final round");

   a_pass_range: assert property (@(posedge clock) disable iff (reset)
      pass_ff != 2'd3)
      else $error("pass counter out of range");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.finish && cmd.pass_done) && !(cmd.load && cmd.round))
      else $error("conflicting datapath commands");

endmodule

@@ hdl/des_dp.sv @@
// feistel halves, rotating key halves and result register of the des core
module des_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  des_pkg::des_cmd_type cmd,
   input  logic [63:0]          data_block,
   input  logic [63:0]          key_one,
   input  logic [63:0]          key_two,
   output logic                 rsp_valid,
   output logic [63:0]          rsp_result_block
);
   import des_pkg::*;

   logic [31:0] l_ff, l_in;
   logic [31:0] r_ff, r_in;
   logic [27:0] c_ff, c_in;
   logic [27:0] d_ff, d_in;
   logic [63:0] result_ff, result_in;
   logic        valid_ff, valid_in;

   logic [27:0] c_use, d_use;
   logic [47:0] subkey;
   logic [31:0] f_out;
   logic [63:0] ip_block;
   logic [55:0] cd_load;
   logic [63:0] load_key;

   always_comb begin
      // encrypt rotates before using the subkey, decrypt rotates back afterwards
      c_use    = cmd.decrypt ? c_ff : rot_left(c_ff, cmd.shift_two);
      d_use    = cmd.decrypt ? d_ff : rot_left(d_ff, cmd.shift_two);
      subkey   = pc2_perm({c_use, d_use});
      f_out    = l_ff ^ feistel(r_ff, subkey);
      ip_block = ip_perm(data_block);
      load_key = (cmd.round && cmd.key_two_sel) ? key_two : key_one;
      cd_load  = pc1_perm(load_key);

      l_in      = l_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      result_in = result_ff;
      valid_in  = 1'b0;

      if (cmd.load) begin
         l_in = ip_block[63:32];
         r_in = ip_block[31:0];
         c_in = cd_load[55:28];
         d_in = cd_load[27:0];
      end else if (cmd.round) begin
         if (cmd.pass_done) begin
            // final permutation then initial permutation cancel out
            l_in = f_out;
            c_in = cd_load[55:28];
            d_in = cd_load[27:0];
         end else begin
            l_in = r_ff;
            r_in = f_out;
            c_in = cmd.decrypt ? rot_right(c_ff, cmd.shift_two) : c_use;
            d_in = cmd.decrypt ? rot_right(d_ff, cmd.shift_two) : d_use;
         end
         if (cmd.finish) begin
            result_in = fp_perm({f_out, r_ff});
            valid_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      l_ff      <= l_in;
      r_ff      <= r_in;
      c_ff      <= c_in;
      d_ff      <= d_in;
      result_ff <= result_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_block = result_ff;

endmodule

@@ hdl/des_tdes_block_cipher_core.sv @@
// top level of the des / two-key triple des ede core with its key registers
// one feistel round per cycle through one round unit, for single des and triple des alike;
//   a new transaction is taken only when the core is idle, after the last round of the one before
// reset clears the sequencer, the strobe and the key and mode registers
// the result strobe lasts one cycle; the receiver cannot stall it
module des_tdes_block_cipher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_data_block,
   input  logic        req_mode,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_block,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import des_pkg::*;

   logic [63:0] key_one_ff, key_one_in;
   logic [63:0] key_two_ff, key_two_in;
   logic        triple_ff, triple_in;
   des_cmd_type cmd;

   always_comb begin
      key_one_in = key_one_ff;
      key_two_in = key_two_ff;
      triple_in  = triple_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_ONE:       key_one_in = csr_wdata;
            CSR_KEY_TWO:       key_two_in = csr_wdata;
            CSR_TRIPLE_ENABLE: triple_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_one_ff <= '0;
         key_two_ff <= '0;
         triple_ff  <= 1'b0;
      end else begin
         key_one_ff <= key_one_in;
         key_two_ff <= key_two_in;
         triple_ff  <= triple_in;
      end
   end

   des_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .mode   (req_mode),
      .triple (triple_ff),
      .busy   (busy),
      .cmd    (cmd)
   );

   des_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .data_block       (req_data_block),
      .key_one          (key_one_ff),
      .key_two          (key_two_ff),
      .rsp_valid        (rsp_valid),
      .rsp_result_block (rsp_result_block)
   );

endmodule

@@ tb/des_tb_pkg.sv @@
// bit-exact des / two-key triple des predictor and result scoreboard for the core testbench
package des_tb_pkg;
   import des_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;

   localparam int CHECK_OK         = 0;
   localparam int CHECK_WRONG      = 1;
   localparam int CHECK_UNEXPECTED = 2;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   // key schedule rounds that rotate by one place, the rest rotate by two
   localparam logic [15:0] ONE_PLACE_ROUNDS = 16'h8103;

   // bit maps, first entry in the highest used byte (zero padding above), 1 = msb of the source
   localparam logic [511:0] KEY_SELECT_MAP = {64'd0,
      8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,  8'd58, 8'd50, 8'd42, 8'd34,
      8'd26, 8'd18, 8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
      8'd60, 8'd52, 8'd44, 8'd36, 8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7,
      8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37,
      8'd29, 8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4};

   localparam logic [511:0] SUBKEY_MAP = {128'd0,
      8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,  8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
      8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,  8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
      8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55, 8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
      8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32};

   localparam logic [511:0] INIT_MAP = {
      8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,
      8'd60, 8'd52, 8'd44, 8'd36, 8'd28, 8'd20, 8'd12, 8'd4,
      8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,
      8'd64, 8'd56, 8'd48, 8'd40, 8'd32, 8'd24, 8'd16, 8'd8,
      8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,
      8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
      8'd61, 8'd53, 8'd45, 8'd37, 8'd29, 8'd21, 8'd13, 8'd5,
      8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7};

   localparam logic [511:0] FINAL_MAP = {
      8'd40, 8'd8, 8'd48, 8'd16, 8'd56, 8'd24, 8'd64, 8'd32,
      8'd39, 8'd7, 8'd47, 8'd15, 8'd55, 8'd23, 8'd63, 8'd31,
      8'd38, 8'd6, 8'd46, 8'd14, 8'd54, 8'd22, 8'd62, 8'd30,
      8'd37, 8'd5, 8'd45, 8'd13, 8'd53, 8'd21, 8'd61, 8'd29,
      8'd36, 8'd4, 8'd44, 8'd12, 8'd52, 8'd20, 8'd60, 8'd28,
      8'd35, 8'd3, 8'd43, 8'd11, 8'd51, 8'd19, 8'd59, 8'd27,
      8'd34, 8'd2, 8'd42, 8'd10, 8'd50, 8'd18, 8'd58, 8'd26,
      8'd33, 8'd1, 8'd41, 8'd9,  8'd49, 8'd17, 8'd57, 8'd25};

   localparam logic [511:0] EXPAND_MAP = {128'd0,
      8'd32, 8'd1,  8'd2,  8'd3,  8'd4,  8'd5,  8'd4,  8'd5,  8'd6,  8'd7,  8'd8,  8'd9,
      8'd8,  8'd9,  8'd10, 8'd11, 8'd12, 8'd13, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17,
      8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25,
      8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd1};

   localparam logic [511:0] PERM_MAP = {256'd0,
      8'd16, 8'd7,  8'd20, 8'd21, 8'd29, 8'd12, 8'd28, 8'd17,
      8'd1,  8'd15, 8'd23, 8'd26, 8'd5,  8'd18, 8'd31, 8'd10,
      8'd2,  8'd8,  8'd24, 8'd14, 8'd32, 8'd27, 8'd3,  8'd9,
      8'd19, 8'd13, 8'd30, 8'd6,  8'd22, 8'd11, 8'd4,  8'd25};

   // four rows per s-box, column 0 in the top nibble
   localparam logic [63:0] SBOX_ROWS [32] = '{
      64'hE4D12FB83A6C5907, 64'h0F74E2D1A6CB9538, 64'h41E8D62BFC973A50, 64'hFC8249175B3EA06D,
      64'hF18E6B34972DC05A, 64'h3D47F28EC01A69B5, 64'h0E7BA4D158C6932F, 64'hD8A13F42B67C05E9,
      64'hA09E63F51DC7B428, 64'hD709346A285ECBF1, 64'hD6498F30B12C5AE7, 64'h1AD069874FE3B52C,
      64'h7DE3069A1285BC4F, 64'hD8B56F03472C1AE9, 64'hA690CB7DF13E5284, 64'h3F06A1D8945BC72E,
      64'h2C417AB6853FD0E9, 64'hEB2C47D150FA3986, 64'h421BAD78F9C5630E, 64'hB8C71E2D6F09A453,
      64'hC1AF92680D34E75B, 64'hAF427C9561DE0B38, 64'h9EF528C3704A1DB6, 64'h432C95FABE17608D,
      64'h4B2EF08D3C975A61, 64'hD0B7491AE35C2F86, 64'h14BDC37EAF680592, 64'h6BD814A7950FE23C,
      64'hD2846FB1A93E50C7, 64'h1FD8A374C56B0E92, 64'h7B419CE206ADF358, 64'h21E74A8DFC90356B};

   function automatic logic [63:0] pick_bits(input logic [63:0] src, input int src_w,
                                             input logic [511:0] bit_map, input int count);
      logic [63:0] dst;
      int pos;
      dst = '0;
      for (int i = 0; i < count; i++) begin
         pos = bit_map[8 * (count - 1 - i) +: 8];
         dst = {dst[62:0], src[src_w - pos]};
      end
      return dst;
   endfunction

   function automatic logic [31:0] round_mix(input logic [31:0] r, input logic [47:0] subkey);
      logic [63:0] wide;
      logic [47:0] e;
      logic [5:0]  six;
      logic [1:0]  row;
      logic [31:0] s;
      wide = pick_bits({32'd0, r}, 32, EXPAND_MAP, 48);
      e = wide[47:0] ^ subkey;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         six = e[42 - 6 * i +: 6];
         row = {six[5], six[0]};
         s = {s[27:0], SBOX_ROWS[4 * i + row][60 - 4 * six[4:1] +: 4]};
      end
      wide = pick_bits({32'd0, s}, 32, PERM_MAP, 32);
      return wide[31:0];
   endfunction

   function automatic logic [63:0] des_single_pass(input logic [63:0] key,
                                                   input logic [63:0] blk, input logic dec);
      logic [63:0] wide;
      logic [27:0] c;
      logic [27:0] d;
      logic [47:0] subkeys [16];
      logic [31:0] l;
      logic [31:0] r;
      logic [31:0] t;
      wide = pick_bits(key, 64, KEY_SELECT_MAP, 56);
      c = wide[55:28];
      d = wide[27:0];
      for (int i = 0; i < 16; i++) begin
         if (ONE_PLACE_ROUNDS[i]) begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
         end else begin
            c = {c[25:0], c[27:26]};
            d = {d[25:0], d[27:26]};
         end
         wide = pick_bits({8'd0, c, d}, 56, SUBKEY_MAP, 48);
         subkeys[i] = wide[47:0];
      end
      wide = pick_bits(blk, 64, INIT_MAP, 64);
      l = wide[63:32];
      r = wide[31:0];
      for (int i = 0; i < 16; i++) begin
         t = l ^ round_mix(r, subkeys[dec ? 15 - i : i]);
         l = r;
         r = t;
      end
      return pick_bits({r, l}, 64, FINAL_MAP, 64);
   endfunction

   class des_block_scoreboard;
      logic [63:0] key_one;
      logic [63:0] key_two;
      logic        triple_on;
      logic [63:0] awaited_blocks [$];
      int unsigned matched;

      function new();
         key_one   = '0;
         key_two   = '0;
         triple_on = 1'b0;
         matched   = 0;
      endfunction

      function void write_reg(input logic [1:0] reg_index, input logic [63:0] value);
         case (reg_index)
            CSR_KEY_ONE:       key_one = value;
            CSR_KEY_TWO:       key_two = value;
            CSR_TRIPLE_ENABLE: triple_on = value[0];
            default: ;
         endcase
      endfunction

      function logic [63:0] transform(input logic [63:0] blk, input logic dec);
         logic [63:0] x;
         x = des_single_pass(key_one, blk, dec);
         if (triple_on) begin
            x = des_single_pass(key_two, x, ~dec);
            x = des_single_pass(key_one, x, dec);
         end
         return x;
      endfunction

      function void note_request(input logic [63:0] blk, input logic dec);
         awaited_blocks.push_back(transform(blk, dec));
      endfunction

      function int check_result(input logic [63:0] got, output logic [63:0] want);
         want = '0;
         if (awaited_blocks.size() == 0) return CHECK_UNEXPECTED;
         want = awaited_blocks.pop_front();
         if (got !== want) return CHECK_WRONG;
         matched++;
         return CHECK_OK;
      endfunction
   endclass

endpackage

@@ tb/tb_des_tdes_block_cipher_core.sv @@
// top-level testbench of the des / triple des core: paced transactions, key settings, checking
module tb_des_tdes_block_cipher_core;
   timeunit 1ns;
   timeprecision 1ps;

   import des_pkg::*;
   import des_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 800000;
   localparam int          RANDOM_ROUNDS = 23;
   localparam int          ROUND_ITEMS   = 50;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_data_block;
   logic        req_mode;
   logic        rsp_valid;
   logic [63:0] rsp_result_block;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   des_block_scoreboard block_checker;

   int unsigned cycle_count;
   int          mismatch_count;
   int          sent_count;
   int          setting_count;
   int          triple_count;
   int          burst_left;
   logic [63:0] blk;
   logic [63:0] prev_out;
   logic        dec;
   logic        prev_dec;
   logic        have_prev;

   des_tdes_block_cipher_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_data_block   (req_data_block),
      .req_mode         (req_mode),
      .rsp_valid        (rsp_valid),
      .rsp_result_block (rsp_result_block),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("des_tdes_block_cipher_core: mismatch");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] %s", $realtime, what);
   endtask

   always @(posedge clock) begin : result_monitor
      int          status;
      logic [63:0] want;
      if (!reset && rsp_valid) begin
         status = block_checker.check_result(rsp_result_block, want);
         if (status == CHECK_WRONG)
            report_mismatch($sformatf("result_block got %h expected %h",
                                      rsp_result_block, want));
         else if (status == CHECK_UNEXPECTED)
            report_mismatch($sformatf("result_block %h with no transaction pending",
                                      rsp_result_block));
      end
   end

   task automatic write_csr(input logic [1:0] reg_index, input logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= value;
      block_checker.write_reg(reg_index, value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic note_setting();
      setting_count++;
      if (block_checker.triple_on) triple_count++;
   endtask

   // holds start until the core takes the transaction
   task automatic send_block(input logic [63:0] data, input logic decrypt);
      logic accepted;
      start          <= 1'b1;
      req_data_block <= data;
      req_mode       <= decrypt;
      accepted = 1'b0;
      while (!accepted) begin
         @(posedge clock);
         accepted = !busy;
      end
      block_checker.note_request(data, decrypt);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic paced_send(input logic [63:0] data, input logic decrypt);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: gap = 0;
            8:          gap = $urandom_range(17, 60);
            9:          gap = $urandom_range(1, 4);
            default:    gap = $urandom_range(1, 16);
         endcase
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) begin
               req_data_block <= {$urandom, $urandom};
               req_mode       <= 1'($urandom_range(0, 1));
               @(negedge clock);
            end
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      send_block(data, decrypt);
   endtask

   task automatic finish_phase();
      start <= 1'b0;
      burst_left = 0;
      while (block_checker.awaited_blocks.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [63:0] random_key();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return 64'h0101_0101_0101_0101;
         3:       return 64'hFEFE_FEFE_FEFE_FEFE;
         4:       return 64'h1F1F_1F1F_0E0E_0E0E;
         5:       return 64'd1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [63:0] random_block();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return 64'd1 << $urandom_range(0, 63);
         3:       return ~(64'd1 << $urandom_range(0, 63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      block_checker  = new();
      reset          = 1'b1;
      start          = 1'b0;
      req_data_block = '0;
      req_mode       = MODE_ENCRYPT;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_KEY_ONE;
      csr_wdata      = '0;
      mismatch_count = 0;
      sent_count     = 0;
      setting_count  = 0;
      triple_count   = 0;
      burst_left     = 0;
      have_prev      = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      if (des_single_pass(64'h1334_5779_9BBC_DFF1, 64'h0123_4567_89AB_CDEF, MODE_ENCRYPT)
          !== 64'h85E8_1354_0F0A_B405)
         report_mismatch("predictor disagrees with the standard des test vector");

      // keys as left by reset
      note_setting();
      paced_send('0, MODE_ENCRYPT);
      paced_send('1, MODE_ENCRYPT);
      paced_send('1, MODE_DECRYPT);
      paced_send('0, MODE_DECRYPT);
      finish_phase();

      // single des, stray bits above the triple enable bit, write to the spare index
      write_csr(CSR_KEY_ONE, 64'h1334_5779_9BBC_DFF1);
      write_csr(CSR_KEY_TWO, 64'h0E32_9232_EA6D_0D73);
      write_csr(CSR_TRIPLE_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE);
      write_csr(CSR_SPARE, '1);
      note_setting();
      paced_send(64'h0123_4567_89AB_CDEF, MODE_ENCRYPT);
      paced_send(64'h85E8_1354_0F0A_B405, MODE_DECRYPT);
      paced_send(64'h8000_0000_0000_0000, MODE_ENCRYPT);
      paced_send(64'h0000_0000_0000_0001, MODE_DECRYPT);
      finish_phase();

      // triple des with extreme keys
      write_csr(CSR_KEY_ONE, '1);
      write_csr(CSR_KEY_TWO, '0);
      write_csr(CSR_TRIPLE_ENABLE, 64'h3);
      note_setting();
      paced_send('0, MODE_ENCRYPT);
      paced_send('1, MODE_ENCRYPT);
      paced_send('0, MODE_DECRYPT);
      paced_send('1, MODE_DECRYPT);
      paced_send(64'h0123_4567_89AB_CDEF, MODE_ENCRYPT);
      finish_phase();

      // equal keys: triple des collapses to single des
      write_csr(CSR_KEY_ONE, 64'h0123_4567_89AB_CDEF);
      write_csr(CSR_KEY_TWO, 64'h0123_4567_89AB_CDEF);
      note_setting();
      paced_send(64'h4E6F_7720_6973_2074, MODE_ENCRYPT);
      paced_send({$urandom, $urandom}, MODE_DECRYPT);
      paced_send('1, MODE_DECRYPT);
      finish_phase();

      write_csr(CSR_KEY_ONE, '0);
      write_csr(CSR_KEY_TWO, '1);
      note_setting();
      paced_send('0, MODE_ENCRYPT);
      paced_send('1, MODE_DECRYPT);
      paced_send({$urandom, $urandom}, MODE_ENCRYPT);
      paced_send({$urandom, $urandom}, MODE_DECRYPT);
      finish_phase();

      for (int round_no = 0; round_no < RANDOM_ROUNDS; round_no++) begin
         if ($urandom_range(0, 3) != 0) write_csr(CSR_KEY_ONE, random_key());
         if ($urandom_range(0, 4) == 0)
            write_csr(CSR_KEY_TWO, block_checker.key_one);
         else if ($urandom_range(0, 3) != 0)
            write_csr(CSR_KEY_TWO, random_key());
         if ($urandom_range(0, 5) == 0) write_csr(CSR_SPARE, {$urandom, $urandom});
         write_csr(CSR_TRIPLE_ENABLE, {$urandom, $urandom});
         note_setting();
         have_prev = 1'b0;
         repeat (ROUND_ITEMS) begin
            // a quarter of the blocks run the previous result back the other way
            if (have_prev && $urandom_range(0, 3) == 0) begin
               blk = prev_out;
               dec = ~prev_dec;
            end else begin
               blk = random_block();
               dec = 1'($urandom_range(0, 1));
            end
            prev_out  = block_checker.transform(blk, dec);
            prev_dec  = dec;
            have_prev = 1'b1;
            paced_send(blk, dec);
         end
         finish_phase();
      end

      repeat (60) @(negedge clock);
      $display("ran %0d transactions under %0d key settings (%0d triple des), %0d results checked",
               sent_count, setting_count, triple_count, block_checker.matched);
      $display("blocks and keys spanned zero, all-one, weak and walking-bit values in both directions");
      if (mismatch_count == 0) begin
         $display("des_tdes_block_cipher_core: match");
      end else begin
         $display("des_tdes_block_cipher_core: mismatch");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/des_pkg.sv
hdl/des_ctrl.sv
hdl/des_dp.sv
hdl/des_tdes_block_cipher_core.sv
tb/des_tb_pkg.sv
tb/tb_des_tdes_block_cipher_core.sv
